### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define WSPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wsps assertion failed");

// Concurrent assertion that is also checked during reset.
`define WSPS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wsps assertion failed");

`endif

### rtl/wsps_pkg.sv
package wsps_pkg;

  localparam int RPM_W      = 16;
  localparam int INV_W      = 15;
  localparam int QUOT_W     = 11;
  localparam int SPEED_W    = 21;
  localparam int CNT_W      = 8;
  localparam int RADIUS_W   = 10;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 192;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // floor(x / 60) == (x * DIV60_MUL) >> DIV60_SHIFT for every 16-bit x.
  localparam logic [16:0] DIV60_MUL   = 17'd69906;
  localparam int          DIV60_SHIFT = 22;

  localparam logic [CNT_W-1:0]    STUCK_LIMIT_RST    = 8'd100;
  localparam logic [CNT_W-1:0]    MISMATCH_LIMIT_RST = 8'd100;
  localparam logic [RPM_W-1:0]    TOLERANCE_RST      = 16'd150;
  localparam logic [15:0]         GEAR_RECIP_RST     = 16'd14043;
  localparam logic [RADIUS_W-1:0] RADIUS_RST         = 10'd254;

  localparam int OUT_RPM_RL_LSB = 0;
  localparam int OUT_RPM_RR_LSB = 16;
  localparam int OUT_SPD_FL_LSB = 32;
  localparam int OUT_SPD_FR_LSB = 53;
  localparam int OUT_SPD_RL_LSB = 74;
  localparam int OUT_SPD_RR_LSB = 95;
  localparam int OUT_FA_LSB     = 116;
  localparam int OUT_RA_LSB     = 137;
  localparam int OUT_CH_LSB     = 158;
  localparam int OUT_REAR_BIT   = 179;
  localparam int OUT_FRONT_BIT  = 180;
  localparam int OUT_FAULT_LSB  = 181;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SEL_SENSOR = 2'd1,
    CMD_SEL_MOTOR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_STUCK_LIMIT    = 3'd0,
    REG_MISMATCH_LIMIT = 3'd1,
    REG_TOLERANCE      = 3'd2,
    REG_GEAR_RECIP     = 3'd3,
    REG_RADIUS         = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_rl;
    logic [RPM_W-1:0] rpm_rr;
    logic             rear_from_motor;
    logic             front_from_motor;
    logic [3:0]       fault_bits;
  } carry_t;

endpackage

### rtl/wheel_speed_plausibility_select.sv
// An accepted tick moves from the input stage through s1 to s4 into the output register.
// Throughput: one item per cycle unless out_tready stalls; counters update once per item.
// Clear commands pass through the input stage only and produce no output transfer.
// Reset (rst_n low, synchronous) empties the pipeline, clears counters, fault latches,
// last rpm and source bit, and loads the configuration registers with their defaults.
module wheel_speed_plausibility_select
  import wsps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sensor_rpm_fl, sensor_rpm_fr, sensor_rpm_rl, sensor_rpm_rr, motor_rpm_rl, motor_rpm_rr
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // chosen_rpm_rl, chosen_rpm_rr, speed_fl, speed_fr, speed_rl, speed_rr, front_axle_speed,
  // rear_axle_speed, chassis_speed, rear_from_motor, front_from_motor, fault_bits, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [CNT_W-1:0]    stuck_limit_r;
  logic [CNT_W-1:0]    mismatch_limit_r;
  logic [RPM_W-1:0]    tolerance_r;
  logic [15:0]         gear_recip_r;
  logic [RADIUS_W-1:0] radius_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  logic                 s0_valid_r;
  cmd_t                 s0_cmd_r;
  logic [IN_DATA_W-1:0] s0_data_r;

  logic             s1_valid_r;
  logic [RPM_W-1:0] s1_rpm_fl_r;
  logic [RPM_W-1:0] s1_rpm_fr_r;
  carry_t           s1_carry_r;

  logic              s2_valid_r;
  logic [QUOT_W-1:0] s2_quot_r [4];
  carry_t            s2_carry_r;

  logic               s3_valid_r;
  logic [SPEED_W-1:0] s3_speed_r [4];
  carry_t             s3_carry_r;

  logic               s4_valid_r;
  logic [SPEED_W-1:0] s4_speed_r [4];
  logic [SPEED_W-1:0] s4_fa_r;
  logic [SPEED_W-1:0] s4_ra_r;
  carry_t             s4_carry_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s0_fire;

  logic [RPM_W-1:0] last_rpm_r   [2];
  logic [CNT_W-1:0] stuck_cnt_r  [2];
  logic [CNT_W-1:0] mis_cnt_r    [2];
  logic [1:0]       stuck_lat_r;
  logic [1:0]       mis_lat_r;
  logic             front_src_r;

  logic [RPM_W-1:0] last_rpm_nxt  [2];
  logic [CNT_W-1:0] stuck_cnt_nxt [2];
  logic [CNT_W-1:0] mis_cnt_nxt   [2];
  logic [1:0]       stuck_lat_nxt;
  logic [1:0]       mis_lat_nxt;
  logic             front_src_nxt;

  logic [RPM_W-1:0] sens   [2];
  logic [RPM_W-1:0] motor  [2];
  logic [INV_W-1:0] inv    [2];
  logic [1:0]       stuck_lat_tick;
  logic [1:0]       mis_lat_tick;
  logic [CNT_W-1:0] stuck_cnt_tick [2];
  logic [CNT_W-1:0] mis_cnt_tick   [2];
  logic             rear_motor;
  carry_t           carry_nxt;

  assign sens[0]  = s0_data_r[47:32];
  assign sens[1]  = s0_data_r[63:48];
  assign motor[0] = s0_data_r[79:64];
  assign motor[1] = s0_data_r[95:80];

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stuck_limit_r    <= STUCK_LIMIT_RST;
      mismatch_limit_r <= MISMATCH_LIMIT_RST;
      tolerance_r      <= TOLERANCE_RST;
      gear_recip_r     <= GEAR_RECIP_RST;
      radius_r         <= RADIUS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STUCK_LIMIT:    stuck_limit_r    <= cfg_pwdata[CNT_W-1:0];
        REG_MISMATCH_LIMIT: mismatch_limit_r <= cfg_pwdata[CNT_W-1:0];
        REG_TOLERANCE:      tolerance_r      <= cfg_pwdata[RPM_W-1:0];
        REG_GEAR_RECIP:     gear_recip_r     <= cfg_pwdata[15:0];
        REG_RADIUS:         radius_r         <= cfg_pwdata[RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STUCK_LIMIT:    cfg_prdata = CFG_DATA_W'(stuck_limit_r);
      REG_MISMATCH_LIMIT: cfg_prdata = CFG_DATA_W'(mismatch_limit_r);
      REG_TOLERANCE:      cfg_prdata = CFG_DATA_W'(tolerance_r);
      REG_GEAR_RECIP:     cfg_prdata = CFG_DATA_W'(gear_recip_r);
      REG_RADIUS:         cfg_prdata = CFG_DATA_W'(radius_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Pipeline flow control.
  assign rdy5      = !out_valid_r || out_tready;
  assign rdy4      = !s4_valid_r || rdy5;
  assign rdy3      = !s3_valid_r || rdy4;
  assign rdy2      = !s2_valid_r || rdy3;
  assign rdy1      = !s1_valid_r || rdy2;
  assign rdy0      = !s0_valid_r || rdy1;
  assign in_tready = rdy0;
  assign s0_fire   = s0_valid_r && rdy1;

  // Plausibility checks for both rear wheels.
  always_comb begin
    logic [RPM_W-1:0] neg;
    logic [30:0]      prod;
    logic [INV_W-1:0] scaled;
    logic [RPM_W-1:0] diff;
    logic [CNT_W-1:0] mc_inc;
    for (int w = 0; w < 2; w++) begin
      neg = RPM_W'(~motor[w] + 16'd1);
      if (!motor[w][15]) begin
        inv[w] = motor[w][INV_W-1:0];
      end else if (motor[w] == 16'h8000) begin
        inv[w] = {INV_W{1'b1}};
      end else begin
        inv[w] = neg[INV_W-1:0];
      end

      stuck_lat_tick[w] = stuck_lat_r[w];
      stuck_cnt_tick[w] = stuck_cnt_r[w];
      if (sens[w] == last_rpm_r[w] && inv[w] != '0) begin
        if (stuck_cnt_r[w] > stuck_limit_r) begin
          stuck_lat_tick[w] = 1'b1;
        end else if (stuck_cnt_r[w] != {CNT_W{1'b1}}) begin
          stuck_cnt_tick[w] = stuck_cnt_r[w] + 8'd1;
        end
      end else begin
        stuck_cnt_tick[w] = '0;
      end

      prod   = 31'(inv[w]) * 31'(gear_recip_r);
      scaled = prod[30:16];
      diff   = (sens[w] >= RPM_W'(scaled)) ? sens[w] - RPM_W'(scaled)
                                           : RPM_W'(scaled) - sens[w];
      mc_inc = (mis_cnt_r[w] == {CNT_W{1'b1}}) ? mis_cnt_r[w] : mis_cnt_r[w] + 8'd1;
      mis_lat_tick[w] = mis_lat_r[w];
      if (diff > tolerance_r) begin
        mis_cnt_tick[w] = mc_inc;
        if (mc_inc > mismatch_limit_r) begin
          mis_lat_tick[w] = 1'b1;
        end
      end else begin
        mis_cnt_tick[w] = '0;
      end
    end
  end

  assign rear_motor = |{stuck_lat_tick, mis_lat_tick};

  always_comb begin
    carry_nxt.rpm_rl           = rear_motor ? RPM_W'(inv[0]) : sens[0];
    carry_nxt.rpm_rr           = rear_motor ? RPM_W'(inv[1]) : sens[1];
    carry_nxt.rear_from_motor  = rear_motor;
    carry_nxt.front_from_motor = front_src_r;
    carry_nxt.fault_bits       = {mis_lat_tick[1], mis_lat_tick[0],
                                  stuck_lat_tick[1], stuck_lat_tick[0]};
  end

  always_comb begin
    last_rpm_nxt  = last_rpm_r;
    stuck_cnt_nxt = stuck_cnt_r;
    mis_cnt_nxt   = mis_cnt_r;
    stuck_lat_nxt = stuck_lat_r;
    mis_lat_nxt   = mis_lat_r;
    front_src_nxt = front_src_r;
    if (s0_fire) begin
      case (s0_cmd_r)
        CMD_TICK: begin
          stuck_cnt_nxt   = stuck_cnt_tick;
          mis_cnt_nxt     = mis_cnt_tick;
          stuck_lat_nxt   = stuck_lat_tick;
          mis_lat_nxt     = mis_lat_tick;
          last_rpm_nxt[0] = carry_nxt.rpm_rl;
          last_rpm_nxt[1] = carry_nxt.rpm_rr;
        end
        CMD_SEL_SENSOR, CMD_SEL_MOTOR: begin
          stuck_cnt_nxt = '{default: '0};
          mis_cnt_nxt   = '{default: '0};
          stuck_lat_nxt = '0;
          mis_lat_nxt   = '0;
          front_src_nxt = (s0_cmd_r == CMD_SEL_MOTOR);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rpm_r  <= '{default: '0};
      stuck_cnt_r <= '{default: '0};
      mis_cnt_r   <= '{default: '0};
      stuck_lat_r <= '0;
      mis_lat_r   <= '0;
      front_src_r <= 1'b0;
    end else begin
      last_rpm_r  <= last_rpm_nxt;
      stuck_cnt_r <= stuck_cnt_nxt;
      mis_cnt_r   <= mis_cnt_nxt;
      stuck_lat_r <= stuck_lat_nxt;
      mis_lat_r   <= mis_lat_nxt;
      front_src_r <= front_src_nxt;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) s0_valid_r  <= in_tvalid;
      if (rdy1) s1_valid_r  <= s0_valid_r && (s0_cmd_r == CMD_TICK);
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) s3_valid_r  <= s2_valid_r;
      if (rdy4) s4_valid_r  <= s3_valid_r;
      if (rdy5) out_valid_r <= s4_valid_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    logic [32:0]        qprod;
    logic [RPM_W-1:0]   qin [4];
    logic [SPEED_W:0]   fsum;
    logic [SPEED_W:0]   rsum;
    qin[0] = s1_rpm_fl_r;
    qin[1] = s1_rpm_fr_r;
    qin[2] = s1_carry_r.rpm_rl;
    qin[3] = s1_carry_r.rpm_rr;
    if (rdy0) begin
      s0_cmd_r  <= cmd_t'(in_tuser);
      s0_data_r <= in_tdata;
    end
    if (rdy1) begin
      s1_rpm_fl_r <= s0_data_r[15:0];
      s1_rpm_fr_r <= s0_data_r[31:16];
      s1_carry_r  <= carry_nxt;
    end
    if (rdy2) begin
      for (int i = 0; i < 4; i++) begin
        qprod        = 33'(qin[i]) * 33'(DIV60_MUL);
        s2_quot_r[i] <= qprod[DIV60_SHIFT +: QUOT_W];
      end
      s2_carry_r <= s1_carry_r;
    end
    if (rdy3) begin
      for (int i = 0; i < 4; i++) begin
        s3_speed_r[i] <= SPEED_W'(s2_quot_r[i]) * SPEED_W'(radius_r);
      end
      s3_carry_r <= s2_carry_r;
    end
    if (rdy4) begin
      fsum       = (SPEED_W+1)'(s3_speed_r[0]) + (SPEED_W+1)'(s3_speed_r[1]);
      rsum       = (SPEED_W+1)'(s3_speed_r[2]) + (SPEED_W+1)'(s3_speed_r[3]);
      s4_speed_r <= s3_speed_r;
      s4_fa_r    <= fsum[SPEED_W:1];
      s4_ra_r    <= rsum[SPEED_W:1];
      s4_carry_r <= s3_carry_r;
    end
    if (rdy5) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_comb begin
    logic [SPEED_W:0] csum;
    csum = (SPEED_W+1)'(s4_fa_r) + (SPEED_W+1)'(s4_ra_r);
    out_data_nxt = {7'b0, s4_carry_r.fault_bits, s4_carry_r.front_from_motor,
                    s4_carry_r.rear_from_motor, csum[SPEED_W:1], s4_ra_r, s4_fa_r,
                    s4_speed_r[3], s4_speed_r[2], s4_speed_r[1], s4_speed_r[0],
                    s4_carry_r.rpm_rr, s4_carry_r.rpm_rl};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/wsps_checker.sv
`include "assert_macros.svh"

module wsps_checker
  import wsps_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [RPM_W-1:0]   rpm_rl;
  logic [RPM_W-1:0]   rpm_rr;
  logic [SPEED_W-1:0] fa;
  logic [SPEED_W-1:0] ra;
  logic [SPEED_W-1:0] ch;
  logic               rear_bit;
  logic [3:0]         fault;

  assign rpm_rl   = out_tdata[OUT_RPM_RL_LSB +: RPM_W];
  assign rpm_rr   = out_tdata[OUT_RPM_RR_LSB +: RPM_W];
  assign fa       = out_tdata[OUT_FA_LSB +: SPEED_W];
  assign ra       = out_tdata[OUT_RA_LSB +: SPEED_W];
  assign ch       = out_tdata[OUT_CH_LSB +: SPEED_W];
  assign rear_bit = out_tdata[OUT_REAR_BIT];
  assign fault    = out_tdata[OUT_FAULT_LSB +: 4];

  `WSPS_ASSERT_NR(a_reset_empties, clk, !rst_n |=> !out_tvalid)
  `WSPS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `WSPS_ASSERT(a_rear_src_fault, clk, rst_n, out_tvalid |-> (rear_bit == (fault != 4'b0)))
  `WSPS_ASSERT(a_motor_rpm_range, clk, rst_n, out_tvalid && rear_bit |-> !rpm_rl[15] && !rpm_rr[15])
  `WSPS_ASSERT(a_chassis_bound, clk, rst_n, out_tvalid |-> (ch <= fa || ch <= ra))

endmodule

bind wheel_speed_plausibility_select wsps_checker u_wsps_checker (.*);
